// ===== src/assert_macros.svh =====
// assertion macros shared by the task ring rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rrtr_pkg.sv =====
// types and constants of the round-robin task ring
// no dependencies; used by the interfaces and every module
`timescale 1ns / 1ps
`default_nettype none

package rrtr_pkg;

   localparam int ADDR_W  = 32;
   localparam int WORDS_W = 16;
   localparam int SLOT_W  = 4;
   localparam int OFS_W   = 6;

   localparam logic [ADDR_W-1:0] FRAME_PSR_WORD = 32'h0100_0000;

   // word offsets below the stack end used by the shared address unit
   localparam logic [OFS_W-1:0] OFS_ENTRY = 6'd2;
   localparam logic [OFS_W-1:0] OFS_PSR   = 6'd1;

   typedef enum logic {
      MODE_CREATE = 1'b0,
      MODE_SELECT = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_STATUS = 2'd1,
      KIND_SELECT = 2'd2
   } rsp_kind_type;

   typedef struct packed {
      mode_type                mode;
      logic [ADDR_W-1:0]       stack_base;
      logic [WORDS_W-1:0]      stack_words;
      logic [ADDR_W-1:0]       entry_address;
   } req_payload_type;

   typedef struct packed {
      rsp_kind_type            kind;
      logic [ADDR_W-1:0]       address;
      logic [ADDR_W-1:0]       data;
      logic                    failed;
      logic [SLOT_W-1:0]       slot;
      logic                    last;
   } rsp_payload_type;

   // write port of the slot table
   typedef struct packed {
      logic                    en;
      logic [SLOT_W-1:0]       idx;
      logic [ADDR_W-1:0]       top;
      logic [SLOT_W-1:0]       next;
   } wr_port_type;

endpackage

`default_nettype wire

// ===== src/rrtr_if.sv =====
// valid/ready channels of the task ring: request and response
// depends on rrtr_pkg for the payload structs
`timescale 1ns / 1ps
`default_nettype none

interface rrtr_req_if;
   import rrtr_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rrtr_rsp_if;
   import rrtr_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/round_robin_task_ring.sv =====
// round-robin task ring top level: sequencer, shared address unit, slot table
// depends on rrtr_pkg, rrtr_if, rrtr_addr_unit, rrtr_slot_table, assert_macros.svh
//
//   channel   direction  interface    contents
//   req_chan  in         rrtr_req_if  mode, stack_base, stack_words, entry_address
//   rsp_chan  out        rrtr_rsp_if  kind, address, data, failed, slot, last
//
// a create transaction emits two stack writes (ST_ADDR0, ST_ADDR1), computes the top in ST_TOP,
// scans at most NUM_TASKS slots from slot 0, then emits the status in ST_EMIT; the response side can stall it
// a select transaction makes one or two link steps through the table port
// the three address computations share one adder, one per cycle while the output register is free
// synchronous reset empties the ring and frees every slot; no clearing pass
// req_chan is ready only while the sequencer is idle; a finished response waits
// in the output register while the next transaction is accepted
`timescale 1ns / 1ps
`default_nettype none

module round_robin_task_ring #(
   parameter int NUM_TASKS  = 8,
   parameter int SAVED_REGS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rrtr_req_if.sink   req_chan,
   rrtr_rsp_if.source rsp_chan
);
   import rrtr_pkg::*;

   `include "assert_macros.svh"

   localparam logic [SLOT_W-1:0] SENTINEL = SLOT_W'(NUM_TASKS);
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_TASKS - 1);
   localparam logic [OFS_W-1:0]  OFS_TOP  = OFS_W'(SAVED_REGS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR0,
      ST_ADDR1,
      ST_TOP,
      ST_SCAN,
      ST_WALK,
      ST_PICK,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [WORDS_W-1:0] words_ff, words_in;
   logic [ADDR_W-1:0] entry_ff, entry_in;
   logic [ADDR_W-1:0] top_ff, top_in;
   logic [SLOT_W-1:0] scan_ff, scan_in;
   logic [SLOT_W-1:0] walk_ff, walk_in;
   logic              second_ff, second_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] current_ff, current_in;
   rsp_kind_type      res_kind_ff, res_kind_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic              res_failed_ff, res_failed_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   rsp_payload_type   rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              out_free;
   logic              req_fire;
   logic [OFS_W-1:0]  ofs;
   logic [ADDR_W-1:0] sum;
   logic [SLOT_W-1:0] rd_idx;
   logic [ADDR_W-1:0] rd_top;
   logic [SLOT_W-1:0] rd_next;
   logic [SLOT_W-1:0] link;
   wr_port_type       wr;

   rrtr_addr_unit u_addr (
      .base   (base_ff),
      .words  (words_ff),
      .offset (ofs),
      .sum    (sum)
   );

   rrtr_slot_table #(
      .NUM_TASKS (NUM_TASKS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (rd_idx),
      .rd_top  (rd_top),
      .rd_next (rd_next),
      .wr      (wr)
   );

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign out_free         = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      words_in      = words_ff;
      entry_in      = entry_ff;
      top_in        = top_ff;
      scan_in       = scan_ff;
      walk_in       = walk_ff;
      second_in     = second_ff;
      head_in       = head_ff;
      current_in    = current_ff;
      res_kind_in   = res_kind_ff;
      res_addr_in   = res_addr_ff;
      res_failed_in = res_failed_ff;
      res_slot_in   = res_slot_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      ofs           = OFS_ENTRY;
      rd_idx        = walk_ff;
      wr            = '0;
      link          = (walk_ff < SENTINEL) ? rd_next : head_ff;
      if (link > SENTINEL) begin
         link = SENTINEL;
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               base_in   = req_chan.payload.stack_base;
               words_in  = req_chan.payload.stack_words;
               entry_in  = req_chan.payload.entry_address;
               walk_in   = current_ff;
               second_in = 1'b0;
               state_in  = (req_chan.payload.mode == MODE_CREATE) ? ST_ADDR0 : ST_WALK;
            end
         end
         ST_ADDR0: begin
            ofs = OFS_ENTRY;
            if (out_free) begin
               rsp_in       = '{kind: KIND_WRITE, address: sum, data: entry_ff,
                                failed: 1'b0, slot: '0, last: 1'b0};
               rsp_valid_in = 1'b1;
               state_in     = ST_ADDR1;
            end
         end
         ST_ADDR1: begin
            ofs = OFS_PSR;
            if (out_free) begin
               rsp_in       = '{kind: KIND_WRITE, address: sum, data: FRAME_PSR_WORD,
                                failed: 1'b0, slot: '0, last: 1'b0};
               rsp_valid_in = 1'b1;
               state_in     = ST_TOP;
            end
         end
         ST_TOP: begin
            ofs      = OFS_TOP;
            top_in   = sum;
            scan_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // lowest free slot wins; claim and prepend to the ring
            rd_idx = scan_ff;
            if (rd_top == '0) begin
               wr            = '{en: 1'b1, idx: scan_ff, top: top_ff, next: head_ff};
               head_in       = scan_ff;
               res_kind_in   = KIND_STATUS;
               res_addr_in   = top_ff;
               res_failed_in = 1'b0;
               res_slot_in   = scan_ff;
               state_in      = ST_EMIT;
            end else if (scan_ff == LAST_IDX) begin
               res_kind_in   = KIND_STATUS;
               res_addr_in   = '0;
               res_failed_in = 1'b1;
               res_slot_in   = SENTINEL;
               state_in      = ST_EMIT;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_WALK: begin
            // landing on the sentinel the first time takes one more step
            rd_idx = walk_ff;
            if ((link == SENTINEL) && !second_ff) begin
               walk_in   = SENTINEL;
               second_in = 1'b1;
            end else begin
               walk_in  = link;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            rd_idx        = walk_ff;
            current_in    = walk_ff;
            res_kind_in   = KIND_SELECT;
            res_addr_in   = (walk_ff < SENTINEL) ? rd_top : '0;
            res_failed_in = 1'b0;
            res_slot_in   = walk_ff;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_in       = '{kind: res_kind_ff, address: res_addr_ff, data: '0,
                                failed: res_failed_ff, slot: res_slot_ff, last: 1'b1};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         second_ff    <= 1'b0;
         head_ff      <= SENTINEL;
         current_ff   <= SENTINEL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         head_ff      <= head_in;
         current_ff   <= current_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff       <= base_in;
      words_ff      <= words_in;
      entry_ff      <= entry_in;
      top_ff        <= top_in;
      scan_ff       <= scan_in;
      walk_ff       <= walk_in;
      res_kind_ff   <= res_kind_in;
      res_addr_ff   <= res_addr_in;
      res_failed_ff <= res_failed_in;
      res_slot_ff   <= res_slot_in;
      rsp_ff        <= rsp_in;
   end

   `ASSERT_ALWAYS(a_ptr_range, clock, reset, (current_ff <= SENTINEL) && (head_ff <= SENTINEL), "ring pointer beyond sentinel")
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_fire, state_ff != ST_IDLE, "accepted transaction left sequencer idle")
   `ASSERT_IMPLY(a_claim_free, clock, reset, wr.en, rd_top == '0, "claimed a slot that is in use")
   `ASSERT_IMPLY(a_write_not_last, clock, reset, rsp_valid_ff && (rsp_ff.kind == KIND_WRITE), !rsp_ff.last, "stack write flagged as final response")

endmodule

`default_nettype wire

// ===== src/rrtr_addr_unit.sv =====
// shared stack address unit: base + 4 * (words - offset), wrapping at 32 bits
// depends on rrtr_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrtr_addr_unit (
   input  wire logic [rrtr_pkg::ADDR_W-1:0]  base,
   input  wire logic [rrtr_pkg::WORDS_W-1:0] words,
   input  wire logic [rrtr_pkg::OFS_W-1:0]   offset,
   output logic      [rrtr_pkg::ADDR_W-1:0]  sum
);
   import rrtr_pkg::*;

   logic [ADDR_W-1:0] diff;

   always_comb begin
      diff = ADDR_W'(words) - ADDR_W'(offset);
      sum  = base + {diff[ADDR_W-3:0], 2'b00};
   end

endmodule

`default_nettype wire

// ===== src/rrtr_slot_table.sv =====
// slot table: saved stack top and ring link per task slot
// depends on rrtr_pkg; one read port, one write port
`timescale 1ns / 1ps
`default_nettype none

module rrtr_slot_table #(
   parameter int NUM_TASKS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [rrtr_pkg::SLOT_W-1:0]   rd_idx,
   output logic      [rrtr_pkg::ADDR_W-1:0]   rd_top,
   output logic      [rrtr_pkg::SLOT_W-1:0]   rd_next,
   input  wire rrtr_pkg::wr_port_type         wr
);
   import rrtr_pkg::*;

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   logic [ADDR_W-1:0] top_ff  [NUM_TASKS];
   logic [SLOT_W-1:0] next_ff [NUM_TASKS];

   // zero stack top marks a free slot, so tops clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            top_ff[i] <= '0;
         end
      end else if (wr.en) begin
         top_ff[wr.idx[IDX_W-1:0]] <= wr.top;
      end
   end

   // links are written before they are ever followed
   always_ff @(posedge clock) begin
      if (wr.en) begin
         next_ff[wr.idx[IDX_W-1:0]] <= wr.next;
      end
   end

   assign rd_top  = top_ff[rd_idx[IDX_W-1:0]];
   assign rd_next = next_ff[rd_idx[IDX_W-1:0]];

endmodule

`default_nettype wire
